FILE: src/grg_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian generator package
// Shared constants, configuration register indexes and helper functions
// for the fixed-point ratio-of-uniforms normal deviate generator.
// ----------------------------------------------------------------------------
package grg_pkg;

    localparam int MAX_TRIES_DEF = 64;
    localparam int LOG_BITS_DEF  = 8;

    // Numerator and divisor widths of the ratio v/u.
    localparam int NUM_W = 47;
    localparam int DEN_W = 30;

    localparam logic [63:0] GEN_INIT    = 64'd4101842887655102017;
    localparam logic [63:0] GEN_MULT    = 64'd2685821657736338717;
    localparam logic [63:0] SEED_RESET  = 64'd17;
    localparam logic [31:0] MEAN_RESET  = 32'd0;
    localparam logic [30:0] SCALE_RESET = 31'd65536;

    localparam logic [31:0] K_V   = 32'd1842111473;
    localparam logic [30:0] K_X   = 31'd483045308;
    localparam logic [30:0] K_Y   = 31'd415103220;
    localparam logic [31:0] K_C1  = 32'd210453398;
    localparam logic [31:0] K_C2  = 32'd273503517;
    localparam logic signed [32:0] K_LO = 33'sd296320531;
    localparam logic signed [32:0] K_HI = 33'sd298994148;
    localparam logic [31:0] K_LN2 = 32'd744261118;

    localparam logic [1:0] CFG_SEED  = 2'd0;
    localparam logic [1:0] CFG_MEAN  = 2'd1;
    localparam logic [1:0] CFG_SCALE = 2'd2;

    function automatic logic [63:0] f_xorshift(input logic [63:0] s);
        logic [63:0] s1;
        logic [63:0] s2;
        s1 = s ^ (s >> 21);
        s2 = s1 ^ (s1 << 35);
        return s2 ^ (s2 >> 4);
    endfunction

    // Q2.30 rounding of a product, half up on the magnitude.
    function automatic logic [33:0] f_rnd30(input logic [63:0] p);
        logic [63:0] t;
        t = (p + 64'd536870912) >> 30;
        return t[33:0];
    endfunction

    // Long division by shift and subtract, used only to build the log table.
    function automatic logic [63:0] f_udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int          i;
        rem = '0;
        q   = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + k/2^b) in Q2.30 as 2*atanh(k/(2^(b+1)+k)) by its series.
    function automatic logic [31:0] f_log_entry(input int b, input int k);
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        int          j;
        den  = (64'd2 << b) + 64'(k);
        z    = f_udiv64(64'(k) << 31, den);
        z2   = (z * z) >> 31;
        term = z;
        acc  = '0;
        for (j = 0; j < 64; j++) begin
            if (term != 64'd0) begin
                acc  = acc + f_udiv64(term, 64'(2 * j + 1));
                term = (term * z2) >> 31;
            end
        end
        return acc[31:0];
    endfunction

endpackage

FILE: src/grg_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32 x 32 unsigned multiplier with a registered product; every product
// of the datapath goes through it, one per cycle.
// ----------------------------------------------------------------------------
module grg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/grg_div.sv
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring divider, one quotient bit per cycle, for v/u in Q16.16.
// ----------------------------------------------------------------------------
module grg_div
    import grg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             take;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift in where the numerator bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DEN_W-1:0];
            end
            r_quo <= {r_quo[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: src/grg_logtab.sv
// ----------------------------------------------------------------------------
// Log table
// Constant table of ln(1 + k/2^B) in Q2.30, read at an entry and the next.
// ----------------------------------------------------------------------------
module grg_logtab
    import grg_pkg::*;
#(
    parameter int LOG_TABLE_BITS = LOG_BITS_DEF
) (
    input  logic [LOG_TABLE_BITS-1:0] i_idx,
    output logic [31:0]               o_lo,
    output logic [31:0]               o_hi
);

    localparam int TAB_SIZE = (1 << LOG_TABLE_BITS) + 1;

    logic [31:0]             tab [TAB_SIZE];
    logic [LOG_TABLE_BITS:0] idx_next;

    for (genvar k = 0; k < TAB_SIZE; k++) begin : g_tab
        localparam logic [31:0] ENTRY = f_log_entry(LOG_TABLE_BITS, k);
        assign tab[k] = ENTRY;
    end

    assign idx_next = {1'b0, i_idx} + 1'b1;
    assign o_lo     = tab[i_idx];
    assign o_hi     = tab[idx_next];

endmodule

FILE: src/gaussian_random_generator.sv
// ----------------------------------------------------------------------------
// Gaussian random generator
// One normal deviate per item: xorshift draws, Leva's ratio-of-uniforms test
// and mean + scale * v/u in Q16.16, all products on one shared multiplier.
// A candidate pair is decided by the quadratic bounds or, between them, by the
// log test; a rejected pair passes the reject state and an accepted one goes to
// the ratio, scaling and result register. A reseed adds one more multiply pass.
// Throughput: one item at a time; the next is taken once the result is
// registered. Synchronous reset restores the config and control registers and
// marks the generator for seeding from the reset seed at the first item.
// ----------------------------------------------------------------------------
module gaussian_random_generator
    import grg_pkg::*;
#(
    parameter int MAX_TRIES      = MAX_TRIES_DEF,
    parameter int LOG_TABLE_BITS = LOG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_deviate,
    output logic [6:0]         o_tries,
    output logic               o_gave_up,
    output logic               o_saturated
);

    localparam int SH = 31 - LOG_TABLE_BITS;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_G0   = 5'd1;
    localparam logic [4:0] S_G1   = 5'd2;
    localparam logic [4:0] S_G2   = 5'd3;
    localparam logic [4:0] S_G3   = 5'd4;
    localparam logic [4:0] S_G4   = 5'd5;
    localparam logic [4:0] S_AV0  = 5'd6;
    localparam logic [4:0] S_AV1  = 5'd7;
    localparam logic [4:0] S_Q0   = 5'd8;
    localparam logic [4:0] S_Q1   = 5'd9;
    localparam logic [4:0] S_Q2   = 5'd10;
    localparam logic [4:0] S_Q3   = 5'd11;
    localparam logic [4:0] S_Q4   = 5'd12;
    localparam logic [4:0] S_Q5   = 5'd13;
    localparam logic [4:0] S_N0   = 5'd14;
    localparam logic [4:0] S_N1   = 5'd15;
    localparam logic [4:0] S_L0   = 5'd16;
    localparam logic [4:0] S_L1   = 5'd17;
    localparam logic [4:0] S_L2   = 5'd18;
    localparam logic [4:0] S_L3   = 5'd19;
    localparam logic [4:0] S_L4   = 5'd20;
    localparam logic [4:0] S_L5   = 5'd21;
    localparam logic [4:0] S_L6   = 5'd22;
    localparam logic [4:0] S_L7   = 5'd23;
    localparam logic [4:0] S_L8   = 5'd24;
    localparam logic [4:0] S_REJ  = 5'd25;
    localparam logic [4:0] S_D0   = 5'd26;
    localparam logic [4:0] S_D1   = 5'd27;
    localparam logic [4:0] S_S0   = 5'd28;
    localparam logic [4:0] S_S1   = 5'd29;
    localparam logic [4:0] S_S2   = 5'd30;
    localparam logic [4:0] S_OUT  = 5'd31;

    // Configuration and control.
    logic [63:0]        r_seed;
    logic signed [31:0] r_mean;
    logic [30:0]        r_scale;
    logic [4:0]         r_st;
    logic               r_need_seed;
    logic               r_seeding;
    logic               r_draw_w;
    logic [6:0]         r_tries;
    logic [2:0]         r_nstep;
    logic               r_out_valid;

    // Datapath.
    logic [63:0]        r_gen;
    logic [31:0]        r_acc;
    logic [31:0]        r_lo;
    logic [31:0]        r_uu;
    logic [31:0]        r_w;
    logic               r_vneg;
    logic [29:0]        r_av;
    logic [29:0]        r_qa;
    logic [28:0]        r_qb;
    logic signed [31:0] r_d;
    logic [31:0]        r_norm;
    logic [4:0]         r_lz;
    logic [31:0]        r_t0;
    logic [31:0]        r_lm;
    logic [34:0]        r_nl;
    logic [63:0]        r_sum;
    logic [31:0]        r_t;
    logic [35:0]        r_rhs;
    logic [NUM_W-1:0]   r_r;
    logic signed [31:0] r_res;
    logic               r_res_gave;
    logic               r_res_sat;
    logic signed [31:0] r_out_dev;
    logic [6:0]         r_out_tries;
    logic               r_out_gave;
    logic               r_out_sat;

    logic               in_acc;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [31:0]        gen_hi;
    logic [29:0]        u;
    logic [31:0]        mag;
    logic signed [30:0] x;
    logic [29:0]        ax;
    logic [30:0]        y;
    logic [30:0]        ad;
    logic [33:0]        rnd;
    logic signed [31:0] c_s;
    logic signed [32:0] e_s;
    logic signed [32:0] q;
    logic [5:0]         sa;
    logic [31:0]        top_mask;
    logic [LOG_TABLE_BITS-1:0] tab_idx;
    logic [SH-1:0]      tab_rem;
    logic [31:0]        tab_lo;
    logic [31:0]        tab_hi;
    logic [63:0]        interp;
    logic [35:0]        nl;
    logic [63:0]        lsum;
    logic [63:0]        tq;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_num;
    logic [NUM_W-1:0]   div_quot;
    logic [78:0]        full;
    logic               big;
    logic [78:0]        pr;
    logic signed [48:0] res;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_st != S_IDLE;

    assign gen_hi = r_acc + prod[31:0];
    assign u      = r_uu[31:2];
    assign mag    = r_w[31] ? {1'b0, r_w[30:0]} : 32'h8000_0000 - r_w;
    assign x      = $signed({1'b0, u}) - $signed(K_X);
    assign ax     = x[30] ? 30'(-x) : x[29:0];
    assign y      = {1'b0, r_av} + K_Y;
    assign ad     = r_d[31] ? 31'(-r_d) : r_d[30:0];
    assign rnd    = f_rnd30(prod);
    assign c_s    = x[30] ? -$signed({3'b0, rnd[28:0]}) : $signed({3'b0, rnd[28:0]});
    assign e_s    = r_d[31] ? -$signed({2'b0, rnd[30:0]}) : $signed({2'b0, rnd[30:0]});
    assign q      = $signed({3'b0, r_qa}) + e_s;

    // Leading-zero search on the first uniform, halving the step each cycle.
    assign sa       = 6'd16 >> r_nstep;
    assign top_mask = ~(32'hFFFF_FFFF >> sa);
    assign tab_idx  = r_norm[30:SH];
    assign tab_rem  = r_norm[SH-1:0];
    assign interp   = prod >> SH;
    assign nl       = prod[35:0] - {4'b0, r_lm};
    assign lsum     = r_sum + {prod[31:0], 32'b0};
    assign tq       = (lsum + 64'd536870912) >> 30;

    assign div_start = r_st == S_D0;
    assign div_num   = {r_av, 16'b0} + NUM_W'(u >> 1);

    assign full = {15'b0, r_sum} + {prod[46:0], 32'b0};
    assign big  = full > (79'd1 << 62);
    assign pr   = (full + 79'd32768) >> 16;
    assign res  = r_vneg ? 49'(r_mean) - $signed({2'b0, pr[46:0]})
                         : 49'(r_mean) + $signed({2'b0, pr[46:0]});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            S_G1: begin
                mul_a = r_gen[31:0];
                mul_b = GEN_MULT[31:0];
            end
            S_G2: begin
                mul_a = r_gen[63:32];
                mul_b = GEN_MULT[31:0];
            end
            S_G3: begin
                mul_a = r_gen[31:0];
                mul_b = GEN_MULT[63:32];
            end
            S_AV0: begin
                mul_a = K_V;
                mul_b = mag;
            end
            S_Q0: begin
                mul_a = {2'b0, ax};
                mul_b = {2'b0, ax};
            end
            S_Q1: begin
                mul_a = K_C1;
                mul_b = {1'b0, y};
            end
            S_Q2: begin
                mul_a = K_C2;
                mul_b = {2'b0, ax};
            end
            S_Q4: begin
                mul_a = {1'b0, y};
                mul_b = {1'b0, ad};
            end
            S_L0: begin
                mul_a = tab_hi - tab_lo;
                mul_b = 32'(tab_rem);
            end
            S_L1: begin
                mul_a = 32'(r_lz) + 32'd1;
                mul_b = K_LN2;
            end
            S_L3: begin
                mul_a = {2'b0, u};
                mul_b = r_nl[31:0];
            end
            S_L4: begin
                mul_a = {2'b0, u};
                mul_b = {29'b0, r_nl[34:32]};
            end
            S_L6: begin
                mul_a = r_t;
                mul_b = {2'b0, u};
            end
            S_L7: begin
                mul_a = {2'b0, r_av};
                mul_b = {2'b0, r_av};
            end
            S_S0: begin
                mul_a = {1'b0, r_scale};
                mul_b = r_r[31:0];
            end
            S_S1: begin
                mul_a = {1'b0, r_scale};
                mul_b = 32'(r_r[NUM_W-1:32]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    grg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    grg_logtab #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_logtab (
        .i_idx (tab_idx),
        .o_lo  (tab_lo),
        .o_hi  (tab_hi)
    );

    grg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (u),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= SEED_RESET;
            r_mean  <= MEAN_RESET;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEED:  r_seed  <= i_cfg_data;
                CFG_MEAN:  r_mean  <= i_cfg_data[31:0];
                CFG_SCALE: r_scale <= i_cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_need_seed <= 1'b1;
            r_seeding   <= 1'b0;
            r_draw_w    <= 1'b0;
            r_tries     <= '0;
            r_nstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the result state the output register is reloaded instead.
            if (r_out_valid && !i_out_stall && r_st != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_tries  <= '0;
                        r_draw_w <= 1'b0;
                        if (i_restart || r_need_seed) begin
                            // Before reset's first item the reset seed still rules.
                            r_gen       <= f_xorshift(GEN_INIT ^
                                           (i_restart ? r_seed : SEED_RESET));
                            r_seeding   <= 1'b1;
                            r_need_seed <= 1'b0;
                            r_st        <= S_G1;
                        end else begin
                            r_st <= S_G0;
                        end
                    end
                end
                S_G0: begin
                    r_gen <= f_xorshift(r_gen);
                    r_st  <= S_G1;
                end
                S_G1: r_st <= S_G2;
                S_G2: begin
                    r_acc <= prod[63:32];
                    r_lo  <= prod[31:0];
                    r_st  <= S_G3;
                end
                S_G3: begin
                    r_acc <= gen_hi;
                    r_st  <= S_G4;
                end
                S_G4: begin
                    if (r_seeding) begin
                        r_gen     <= {gen_hi, r_lo};
                        r_seeding <= 1'b0;
                        r_st      <= S_G0;
                    end else if (!r_draw_w) begin
                        r_uu     <= gen_hi;
                        r_draw_w <= 1'b1;
                        r_st     <= S_G0;
                    end else begin
                        r_w      <= gen_hi;
                        r_draw_w <= 1'b0;
                        r_tries  <= r_tries + 1'b1;
                        r_st     <= S_AV0;
                    end
                end
                S_AV0: begin
                    r_vneg <= !r_w[31];
                    r_st   <= S_AV1;
                end
                S_AV1: begin
                    r_av <= 30'((prod + 64'h8000_0000) >> 32);
                    r_st <= (u == '0) ? S_REJ : S_Q0;
                end
                S_Q0: r_st <= S_Q1;
                S_Q1: begin
                    r_qa <= rnd[29:0];
                    r_st <= S_Q2;
                end
                S_Q2: begin
                    r_qb <= rnd[28:0];
                    r_st <= S_Q3;
                end
                S_Q3: begin
                    r_d  <= $signed({3'b0, r_qb}) - c_s;
                    r_st <= S_Q4;
                end
                S_Q4: r_st <= S_Q5;
                S_Q5: begin
                    if (q <= K_LO) begin
                        r_st <= S_D0;
                    end else if (q <= K_HI) begin
                        r_st <= S_N0;
                    end else begin
                        r_st <= S_REJ;
                    end
                end
                S_N0: begin
                    r_norm  <= r_uu;
                    r_lz    <= '0;
                    r_nstep <= '0;
                    r_st    <= S_N1;
                end
                S_N1: begin
                    if ((r_norm & top_mask) == '0) begin
                        r_norm <= r_norm << sa;
                        r_lz   <= r_lz + sa[4:0];
                    end
                    r_nstep <= r_nstep + 1'b1;
                    if (r_nstep == 3'd4) begin
                        r_st <= S_L0;
                    end
                end
                S_L0: begin
                    r_t0 <= tab_lo;
                    r_st <= S_L1;
                end
                S_L1: begin
                    r_lm <= r_t0 + interp[31:0];
                    r_st <= S_L2;
                end
                S_L2: begin
                    r_nl <= nl[34:0];
                    r_st <= S_L3;
                end
                S_L3: r_st <= S_L4;
                S_L4: begin
                    r_sum <= prod;
                    r_st  <= S_L5;
                end
                S_L5: begin
                    r_t  <= tq[31:0];
                    r_st <= S_L6;
                end
                S_L6: r_st <= S_L7;
                S_L7: begin
                    r_rhs <= {rnd, 2'b0};
                    r_st  <= S_L8;
                end
                S_L8: begin
                    r_st <= ({2'b0, rnd} <= r_rhs) ? S_D0 : S_REJ;
                end
                S_REJ: begin
                    if (r_tries == 7'(MAX_TRIES)) begin
                        r_res      <= r_mean;
                        r_res_gave <= 1'b1;
                        r_res_sat  <= 1'b0;
                        r_st       <= S_OUT;
                    end else begin
                        r_st <= S_G0;
                    end
                end
                S_D0: r_st <= S_D1;
                S_D1: begin
                    if (div_done) begin
                        r_r  <= div_quot;
                        r_st <= S_S0;
                    end
                end
                S_S0: r_st <= S_S1;
                S_S1: begin
                    r_sum <= prod;
                    r_st  <= S_S2;
                end
                S_S2: begin
                    r_res_gave <= 1'b0;
                    if (big) begin
                        r_res     <= r_vneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        r_res_sat <= 1'b1;
                    end else if (res > 49'sd2147483647) begin
                        r_res     <= 32'sh7FFF_FFFF;
                        r_res_sat <= 1'b1;
                    end else if (res < -49'sd2147483648) begin
                        r_res     <= 32'sh8000_0000;
                        r_res_sat <= 1'b1;
                    end else begin
                        r_res     <= res[31:0];
                        r_res_sat <= 1'b0;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_dev   <= r_res;
                        r_out_tries <= r_tries;
                        r_out_gave  <= r_res_gave;
                        r_out_sat   <= r_res_sat;
                        r_st        <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_deviate   = r_out_dev;
    assign o_tries     = r_out_tries;
    assign o_gave_up   = r_out_gave;
    assign o_saturated = r_out_sat;

endmodule

FILE: src/grg_chk.sv
// ----------------------------------------------------------------------------
// Gaussian generator checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module grg_chk #(
    parameter int MAX_TRIES = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_deviate,
    input logic [6:0]         o_tries,
    input logic               o_gave_up,
    input logic               o_saturated
);

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_deviate))
        else $error("stalled result changed");

    // Every result reports between one and the cap of candidate pairs.
    a_tries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_tries != 7'd0 && o_tries <= 7'(MAX_TRIES))
        else $error("try count out of range");

    // Giving up happens only at the cap and never with clipping.
    a_gave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_gave_up |-> o_tries == 7'(MAX_TRIES) && !o_saturated)
        else $error("give-up result inconsistent");

    // An accepted item keeps the input stalled while it is worked on.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind gaussian_random_generator grg_chk #(.MAX_TRIES(MAX_TRIES)) u_grg_chk (.*);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Gaussian random generator testbench
// Drives items, with and without restart, through the valid/stall handshake,
// changes the seed, mean and scale registers between items, and checks every
// deviate, try count and flag against a cycle-free predictor of the generator.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grg_pkg::*;

    typedef struct packed {
        logic signed [31:0] deviate;
        logic [6:0]         tries;
        logic               gave_up;
        logic               saturated;
    } t_deviate;

    localparam int TRY_CAP  = 64;
    localparam int TAB_BITS = 8;
    localparam int TAB_LEN  = (1 << TAB_BITS) + 1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_SEED;
    logic [63:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_restart = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_deviate;
    logic [6:0]         o_tries;
    logic               o_gave_up;
    logic               o_saturated;

    gaussian_random_generator dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state.
    longint unsigned gen_state;
    longint unsigned seed_reg;
    longint          mean_reg;
    longint unsigned scale_reg;
    longint unsigned ln_table[TAB_LEN];

    t_deviate pending_deviates[$];
    int       errors = 0;
    int       checked = 0;
    int       saturations = 0;
    int       restarts = 0;
    int       max_seen_tries = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    function automatic longint unsigned shuffle64(longint unsigned s);
        s ^= s >> 21;
        s ^= s << 35;
        s ^= s >> 4;
        return s;
    endfunction

    function automatic longint unsigned next_uniform();
        longint unsigned p;
        gen_state = shuffle64(gen_state);
        p = gen_state * GEN_MULT;
        return p >> 32;
    endfunction

    function automatic void reload_generator();
        gen_state = shuffle64(GEN_INIT ^ seed_reg) * GEN_MULT;
    endfunction

    function automatic void build_ln_table();
        longint unsigned den, z, z2, term, acc;
        for (int k = 0; k < TAB_LEN; k++) begin
            den  = (64'd2 << TAB_BITS) + k;
            z    = (longint'(k) << 31) / den;
            z2   = (z * z) >> 31;
            term = z;
            acc  = 0;
            for (int j = 0; j < 64 && term != 0; j++) begin
                acc += term / (2 * j + 1);
                term = (term * z2) >> 31;
            end
            ln_table[k] = acc;
        end
    endfunction

    // Q2.30 product, rounded half away from zero.
    function automatic longint q30_mul(longint a, longint b);
        longint unsigned ua, ub, p;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p  = (ua * ub + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // -ln(x / 2^32) in Q2.30 for nonzero x.
    function automatic longint unsigned minus_ln(longint unsigned x);
        int              e, sh;
        longint unsigned frac, idx, rest, lm;
        e  = 31;
        sh = 31 - TAB_BITS;
        while (e > 0 && x[e] == 1'b0) e--;
        frac = (x << (31 - e)) & 64'h7FFF_FFFF;
        idx  = frac >> sh;
        rest = frac & ((64'd1 << sh) - 1);
        lm   = ln_table[idx] + (((ln_table[idx + 1] - ln_table[idx]) * rest) >> sh);
        return longint'(32 - e) * longint'(K_LN2) - lm;
    endfunction

    function automatic t_deviate predict_deviate(bit restart);
        t_deviate        r;
        int              n;
        bit              ok, neg, sat;
        longint          u, av, x, y, q, res;
        longint unsigned uu, w, mag, nl, t, rhs, v2, ratio, p;
        n   = 0;
        ok  = 0;
        neg = 0;
        sat = 0;
        u   = 0;
        av  = 0;
        if (restart) reload_generator();
        while (n < TRY_CAP && !ok) begin
            uu = next_uniform();
            w  = next_uniform();
            n++;
            u   = uu >> 2;
            neg = w < 64'h8000_0000;
            mag = neg ? 64'h8000_0000 - w : w - 64'h8000_0000;
            av  = (longint'(K_V) * mag + 64'h8000_0000) >> 32;
            if (u == 0) continue;
            x = u - longint'(K_X);
            y = av + longint'(K_Y);
            q = q30_mul(x, x) + q30_mul(y, q30_mul(longint'(K_C1), y)
                                           - q30_mul(longint'(K_C2), x));
            if (q <= longint'(K_LO)) begin
                ok = 1;
            end else if (q <= longint'(K_HI)) begin
                // Band between the quadratic bounds: exact log test.
                nl  = minus_ln(uu);
                t   = (u * nl + (64'd1 << 29)) >> 30;
                rhs = 4 * ((t * u + (64'd1 << 29)) >> 30);
                v2  = q30_mul(av, av);
                ok  = v2 <= rhs;
            end
        end
        if (!ok) begin
            res = mean_reg;
        end else begin
            ratio = ((longint'(av) << 16) + (u >> 1)) / u;
            if (scale_reg != 0 && ratio > (64'd1 << 62) / scale_reg) begin
                sat = 1;
                res = neg ? -(64'sd1 <<< 61) : (64'sd1 <<< 61);
            end else begin
                p   = (scale_reg * ratio + 64'h8000) >> 16;
                res = neg ? mean_reg - longint'(p) : mean_reg + longint'(p);
            end
            if (res > 64'sd2147483647) begin
                res = 64'sd2147483647;
                sat = 1;
            end else if (res < -64'sd2147483648) begin
                res = -64'sd2147483648;
                sat = 1;
            end
        end
        r.deviate   = res[31:0];
        r.tries     = n[6:0];
        r.gave_up   = !ok;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_deviate want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_deviates.size() == 0) begin
                report_mismatch("unexpected deviate item", o_deviate, 0);
            end else begin
                want = pending_deviates.pop_front();
                checked++;
                if (o_deviate !== want.deviate)
                    report_mismatch("deviate", o_deviate, want.deviate);
                if (o_tries !== want.tries)
                    report_mismatch("tries", o_tries, want.tries);
                if (o_gave_up !== want.gave_up)
                    report_mismatch("gave_up", o_gave_up, want.gave_up);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", o_saturated, want.saturated);
            end
        end
    end

    // Receiver stall.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(bit restart);
        t_deviate want;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_restart  <= $urandom_range(1);
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_in_stall);
        want = predict_deviate(restart);
        pending_deviates = {pending_deviates, want};
        restarts += restart;
        if (want.saturated) saturations++;
        if (want.tries > max_seen_tries) max_seen_tries = want.tries;
    endtask

    // Stops sending and waits until every pending deviate has been checked.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_deviates.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] index, logic [63:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_SEED:  seed_reg = data;
            CFG_MEAN:  mean_reg = longint'(signed'(data[31:0]));
            CFG_SCALE: scale_reg = data[30:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        // The first item draws from the reset seed with no restart.
        for (int i = 0; i < 4; i++) send_item(0);
    endtask

    task automatic test_register_extremes();
        // A seed write alone changes nothing until restart.
        write_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(0);
        send_item(1);
        write_reg(CFG_SEED, 64'd0);
        send_item(1);
        send_item(0);
        write_reg(CFG_MEAN, 64'h7FFF_FFFF);
        write_reg(CFG_SCALE, 64'h7FFF_FFFF);
        for (int i = 0; i < 3; i++) send_item(0);
        write_reg(CFG_MEAN, 64'h8000_0000);
        for (int i = 0; i < 3; i++) send_item(0);
        write_reg(CFG_SCALE, 64'd0);
        send_item(0);
        write_reg(CFG_MEAN, 64'h0000_0001_0000_0000);
        write_reg(CFG_SCALE, 64'hFFFF_FFFF_8000_0001);
        send_item(1);
        // Index three is not a register and must be ignored.
        write_reg(2'd3, 64'h1234_5678_9ABC_DEF0);
        send_item(0);
        write_reg(CFG_SEED, 64'd17);
        write_reg(CFG_MEAN, 64'd0);
        write_reg(CFG_SCALE, 64'd65536);
        send_item(1);
        send_item(0);
    endtask

    function automatic logic [63:0] pick_mean();
        case ($urandom_range(5))
            0: return 64'h7FFF_FFFF;
            1: return 64'h8000_0000;
            2: return 64'd0;
            default: return {$urandom, $urandom_range(32'h0004_0000)} ^ 64'h0;
        endcase
    endfunction

    function automatic logic [63:0] pick_scale();
        case ($urandom_range(5))
            0: return 64'h7FFF_FFFF;
            1: return 64'd0;
            2: return {$urandom, $urandom};
            default: return $urandom_range(32'h0010_0000);
        endcase
    endfunction

    task automatic test_random_phase(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 75 == 74) begin
                write_reg(CFG_SEED, {$urandom, $urandom});
                write_reg(CFG_MEAN, pick_mean());
                write_reg(CFG_SCALE, pick_scale());
            end
            if (i == count / 2) drain();
            send_item($urandom_range(7) == 0);
        end
        drain();
    endtask

    initial begin
        build_ln_table();
        seed_reg  = SEED_RESET;
        mean_reg  = 0;
        scale_reg = SCALE_RESET;
        reload_generator();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_phase(27, 77, 450);
        test_random_phase(77, 27, 450);
        test_random_phase(0, 0, 450);

        repeat (200) @(posedge i_clk);
        $display("Checked %0d deviates (%0d restarts, %0d saturated, up to %0d tries)",
                 checked, restarts, saturations, max_seen_tries);
        $display("Register sweeps covered seed, mean and scale extremes under three stall mixes.");
        if (errors == 0 && pending_deviates.size() == 0) begin
            $display("** gaussian_random_generator: PASSED **");
        end else begin
            $display("** gaussian_random_generator: FAILED **");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("Timeout with %0d deviates outstanding", pending_deviates.size());
        $display("** gaussian_random_generator: FAILED **");
        $finish;
    end

endmodule
